@@ src/fcwd_pkg.sv @@
// shared types and constants of the front coded word decoder
package fcwd_pkg;

   localparam int unsigned LETTER_SLOTS = 8;
   localparam int unsigned POS_W        = 3;
   localparam int unsigned DECODE_STEPS = 2;
   localparam int unsigned ESC_DEPTH    = 16;
   localparam logic [4:0]  ESC_CODE     = 5'd31;
   localparam logic [3:0]  CODE_BITS    = 4'd5;

   typedef enum logic [1:0] {
      ACT_RECORD,
      ACT_NEW_BLOCK,
      ACT_LOAD_DIRECT,
      ACT_LOAD_ESCAPE
   } action_type;

   typedef enum logic [2:0] {
      KIND_RECORD,
      KIND_NEW_BLOCK,
      KIND_LOAD_DIRECT,
      KIND_LOAD_ESCAPE,
      KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_DIRECT,
      SRC_ESCAPE
   } src_type;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] table_index;
      logic [7:0] byte_value;
   } front_item_type;

   typedef struct packed {
      logic             write;
      logic [POS_W-1:0] pos;
      src_type          src;
      logic [4:0]       direct_addr;
      logic [3:0]       escape_addr;
   } slot_type;

   typedef struct packed {
      logic                         clear_letters;
      slot_type [DECODE_STEPS-1:0]  slot;
      logic                         emit;
      logic [4:0]                   total;
      logic [3:0]                   entry;
   } cmd_type;

   typedef struct packed {
      logic [LETTER_SLOTS*8-1:0] text;
      logic [3:0]                length;
      logic [3:0]                entry;
      logic                      too_long;
   } result_type;

endpackage

@@ src/fcwd_front.sv @@
// front end: accepts items, classifies them and queues them for the decoder
module fcwd_front import fcwd_pkg::*; #(
   parameter int unsigned DIRECT_ENTRIES = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [1:0]     action,
   input  logic [4:0]     table_index,
   input  logic [7:0]     byte_value,
   input  logic           pop_head,
   output logic           head_valid,
   output front_item_type head_item
);

   localparam int unsigned FQ_DEPTH = 2;
   localparam int unsigned FQ_PW    = $clog2(FQ_DEPTH);

   front_item_type fq_ff [FQ_DEPTH];
   logic [FQ_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FQ_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FQ_PW:0]   count_ff, count_in;
   logic             accept;
   front_item_type   item;

   always_comb begin
      item.table_index = table_index;
      item.byte_value  = byte_value;
      unique case (action_type'(action))
         ACT_RECORD:      item.kind = KIND_RECORD;
         ACT_NEW_BLOCK:   item.kind = KIND_NEW_BLOCK;
         ACT_LOAD_DIRECT: item.kind = (6'(table_index) < 6'(DIRECT_ENTRIES)) ?
                                      KIND_LOAD_DIRECT : KIND_NOP;
         ACT_LOAD_ESCAPE: item.kind = (6'(table_index) < 6'(ESC_DEPTH)) ?
                                      KIND_LOAD_ESCAPE : KIND_NOP;
         default:         item.kind = KIND_NOP;
      endcase
   end

   assign full       = count_ff == (FQ_PW+1)'(FQ_DEPTH);
   assign accept     = push && !full;
   assign head_valid = count_ff != '0;
   assign head_item  = fq_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_head ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !pop_head) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && pop_head) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fq_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

@@ src/fcwd_parse.sv @@
// bit parser: headers, code extraction and symbol table reads
module fcwd_parse import fcwd_pkg::*; #(
   parameter int unsigned MAX_LETTERS    = 8,
   parameter int unsigned ESCAPE_BITS    = 4,
   parameter int unsigned DIRECT_ENTRIES = 32,
   parameter int unsigned BLOCK_ENTRIES  = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  front_item_type head_item,
   input  logic           advance,
   output logic           pop_head,
   output logic           cmd_valid,
   output cmd_type        cmd,
   output logic [7:0]     direct_letter [DECODE_STEPS],
   output logic [7:0]     escape_letter [DECODE_STEPS]
);

   localparam int unsigned DW       = $clog2(DIRECT_ENTRIES);
   localparam logic [3:0]  ESC_W    = 4'(ESCAPE_BITS);
   localparam logic        ESC_ON   = ESCAPE_BITS > 0;
   localparam logic [11:0] ESC_MASK = 12'((1 << ESCAPE_BITS) - 1);
   localparam logic [11:0] CODE_MASK = 12'h01f;

   logic [7:0] direct_mem [DIRECT_ENTRIES];
   logic [7:0] escape_mem [ESC_DEPTH];

   logic [11:0] store_ff, store_in;
   logic [3:0]  held_ff, held_in;
   logic        expect_ff, expect_in;
   logic        escape_ff, escape_in;
   logic [4:0]  wpos_ff, wpos_in;
   logic [3:0]  remain_ff, remain_in;
   logic [3:0]  entry_ff, entry_in;
   logic        cmd_valid_ff, cmd_valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic [7:0]  direct_letter_ff [DECODE_STEPS];
   logic [7:0]  escape_letter_ff [DECODE_STEPS];

   logic        consume;
   logic        is_record;
   logic        process;
   logic        put;
   logic [3:0]  shift;
   logic [11:0] field;

   always_comb begin
      consume   = head_valid && advance;
      is_record = head_item.kind == KIND_RECORD || head_item.kind == KIND_NEW_BLOCK;
      store_in  = store_ff;
      held_in   = held_ff;
      expect_in = expect_ff;
      escape_in = escape_ff;
      wpos_in   = wpos_ff;
      remain_in = remain_ff;
      entry_in  = entry_ff;
      cmd_in    = '0;
      process   = 1'b0;
      put       = 1'b0;
      shift     = '0;
      field     = '0;

      if (head_item.kind == KIND_NEW_BLOCK) begin
         store_in  = '0;
         held_in   = '0;
         expect_in = 1'b1;
         escape_in = 1'b0;
         wpos_in   = '0;
         remain_in = '0;
         entry_in  = '0;
         cmd_in.clear_letters = 1'b1;
      end

      if (expect_in) begin
         wpos_in   = {1'b0, head_item.byte_value[7:4]};
         remain_in = head_item.byte_value[3:0];
         store_in  = '0;
         held_in   = '0;
         escape_in = 1'b0;
         if (remain_in != 4'd0) begin
            expect_in = 1'b0;
         end
      end else begin
         store_in = {store_in[3:0], head_item.byte_value};
         held_in  = held_in + 4'd8;
         process  = 1'b1;
      end

      // each pass resolves one letter; one byte plus the leftover bits holds at most two
      for (int k = 0; k < DECODE_STEPS; k++) begin
         put = 1'b0;
         if (process && remain_in != 4'd0) begin
            if (!escape_in && held_in >= CODE_BITS) begin
               shift    = held_in - CODE_BITS;
               field    = (store_in >> shift) & CODE_MASK;
               store_in = store_in & ((12'd1 << shift) - 12'd1);
               held_in  = shift;
               if (field[4:0] == ESC_CODE && ESC_ON) begin
                  escape_in = 1'b1;
               end else begin
                  cmd_in.slot[k].src = (field < 12'(DIRECT_ENTRIES)) ? SRC_DIRECT : SRC_ZERO;
                  cmd_in.slot[k].direct_addr = field[4:0];
                  put = 1'b1;
               end
            end
            if (escape_in && held_in >= ESC_W) begin
               shift     = held_in - ESC_W;
               field     = (store_in >> shift) & ESC_MASK;
               store_in  = store_in & ((12'd1 << shift) - 12'd1);
               held_in   = shift;
               escape_in = 1'b0;
               cmd_in.slot[k].src = (field < 12'(ESC_DEPTH)) ? SRC_ESCAPE : SRC_ZERO;
               cmd_in.slot[k].escape_addr = field[3:0];
               put = 1'b1;
            end
            if (put) begin
               cmd_in.slot[k].write = wpos_in < 5'(MAX_LETTERS);
               cmd_in.slot[k].pos   = wpos_in[POS_W-1:0];
               wpos_in   = wpos_in + 5'd1;
               remain_in = remain_in - 4'd1;
            end
         end
      end

      if (remain_in == 4'd0) begin
         cmd_in.emit  = 1'b1;
         cmd_in.total = wpos_in;
         cmd_in.entry = entry_in;
         entry_in  = (entry_in == 4'(BLOCK_ENTRIES - 1)) ? 4'd0 : entry_in + 4'd1;
         expect_in = 1'b1;
         escape_in = 1'b0;
         store_in  = '0;
         held_in   = '0;
      end

      cmd_valid_in = consume && is_record;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff     <= '0;
         held_ff      <= '0;
         expect_ff    <= 1'b1;
         escape_ff    <= 1'b0;
         wpos_ff      <= '0;
         remain_ff    <= '0;
         entry_ff     <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         if (consume && is_record) begin
            store_ff  <= store_in;
            held_ff   <= held_in;
            expect_ff <= expect_in;
            escape_ff <= escape_in;
            wpos_ff   <= wpos_in;
            remain_ff <= remain_in;
            entry_ff  <= entry_in;
         end
         if (advance) begin
            cmd_valid_ff <= cmd_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= cmd_in;
         for (int k = 0; k < DECODE_STEPS; k++) begin
            direct_letter_ff[k] <= direct_mem[cmd_in.slot[k].direct_addr[DW-1:0]];
            escape_letter_ff[k] <= escape_mem[cmd_in.slot[k].escape_addr];
         end
      end
      if (consume && head_item.kind == KIND_LOAD_DIRECT) begin
         direct_mem[head_item.table_index[DW-1:0]] <= head_item.byte_value;
      end
      if (consume && head_item.kind == KIND_LOAD_ESCAPE) begin
         escape_mem[head_item.table_index[3:0]] <= head_item.byte_value;
      end
   end

   assign pop_head      = consume;
   assign cmd_valid     = cmd_valid_ff;
   assign cmd           = cmd_ff;
   assign direct_letter = direct_letter_ff;
   assign escape_letter = escape_letter_ff;

endmodule

@@ src/fcwd_assemble.sv @@
// back end: letter buffer, word packing and result queue
module fcwd_assemble import fcwd_pkg::*; #(
   parameter int unsigned MAX_LETTERS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   input  logic [7:0] direct_letter [DECODE_STEPS],
   input  logic [7:0] escape_letter [DECODE_STEPS],
   output logic       advance,
   output logic       empty,
   input  logic       pop,
   output result_type result
);

   localparam int unsigned OQ_DEPTH = 2;
   localparam int unsigned OQ_PW    = $clog2(OQ_DEPTH);

   logic [7:0]  letters_ff [LETTER_SLOTS];
   logic [7:0]  letters_in [LETTER_SLOTS];
   result_type  oq_ff [OQ_DEPTH];
   logic [OQ_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OQ_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_PW:0]   count_ff, count_in;

   logic        out_full;
   logic        out_push;
   logic        out_pop;
   logic [7:0]  letter;
   logic [3:0]  length;
   result_type  result_in;

   always_comb begin
      out_full = count_ff == (OQ_PW+1)'(OQ_DEPTH);
      advance  = !(cmd_valid && cmd.emit && out_full);
      out_push = cmd_valid && cmd.emit && advance;
      out_pop  = pop && !empty;
      letter   = '0;

      letters_in = letters_ff;
      if (cmd.clear_letters) begin
         for (int i = 0; i < LETTER_SLOTS; i++) begin
            letters_in[i] = '0;
         end
      end
      for (int k = 0; k < DECODE_STEPS; k++) begin
         case (cmd.slot[k].src)
            SRC_DIRECT: letter = direct_letter[k];
            SRC_ESCAPE: letter = escape_letter[k];
            default:    letter = '0;
         endcase
         if (cmd.slot[k].write) begin
            letters_in[cmd.slot[k].pos] = letter;
         end
      end

      length = (cmd.total > 5'(MAX_LETTERS)) ? 4'(MAX_LETTERS) : cmd.total[3:0];
      if (cmd.emit) begin
         for (int i = 0; i < LETTER_SLOTS; i++) begin
            if (4'(i) >= length) begin
               letters_in[i] = '0;
            end
         end
      end

      for (int i = 0; i < LETTER_SLOTS; i++) begin
         result_in.text[8*i +: 8] = letters_in[i];
      end
      result_in.length   = length;
      result_in.entry    = cmd.entry;
      result_in.too_long = cmd.total > 5'(MAX_LETTERS);

      wr_ptr_in = out_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (out_push && !out_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LETTER_SLOTS; i++) begin
            letters_ff[i] <= '0;
         end
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd_valid && advance) begin
            letters_ff <= letters_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         oq_ff[wr_ptr_ff] <= result_in;
      end
   end

   assign empty  = count_ff == '0;
   assign result = oq_ff[rd_ptr_ff];

endmodule

@@ src/front_coded_word_decoder.sv @@
// top level of the front coded word decoder
//
// channel   direction  handshake           transaction
// req_*     in         push / full         record byte, new block byte or table load
// rsp_*     out        empty / pop         one decoded word with position and flags
//
// one item per cycle unless stalled; a result is registered in the parser, then in the result queue
// a record byte resolves up to two letters in the parser; symbol reads are registered
// reset clears decoder state; symbol tables hold garbage until loaded
// a full result queue stalls the parser, and the input queue then fills and raises full
module front_coded_word_decoder import fcwd_pkg::*; #(
   parameter int unsigned MAX_LETTERS    = 8,
   parameter int unsigned ESCAPE_BITS    = 4,
   parameter int unsigned DIRECT_ENTRIES = 32,
   parameter int unsigned BLOCK_ENTRIES  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_table_index,
   input  logic [7:0]  req_byte_value,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_word_text,
   output logic [3:0]  rsp_word_length,
   output logic [3:0]  rsp_entry_in_block,
   output logic        rsp_too_long
);

   logic           head_valid;
   front_item_type head_item;
   logic           pop_head;
   logic           advance;
   logic           cmd_valid;
   cmd_type        cmd;
   logic [7:0]     direct_letter [DECODE_STEPS];
   logic [7:0]     escape_letter [DECODE_STEPS];
   result_type     result;

   fcwd_front #(
      .DIRECT_ENTRIES (DIRECT_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .action      (req_action),
      .table_index (req_table_index),
      .byte_value  (req_byte_value),
      .pop_head    (pop_head),
      .head_valid  (head_valid),
      .head_item   (head_item)
   );

   fcwd_parse #(
      .MAX_LETTERS    (MAX_LETTERS),
      .ESCAPE_BITS    (ESCAPE_BITS),
      .DIRECT_ENTRIES (DIRECT_ENTRIES),
      .BLOCK_ENTRIES  (BLOCK_ENTRIES)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .advance       (advance),
      .pop_head      (pop_head),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .direct_letter (direct_letter),
      .escape_letter (escape_letter)
   );

   fcwd_assemble #(
      .MAX_LETTERS (MAX_LETTERS)
   ) u_assemble (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .direct_letter (direct_letter),
      .escape_letter (escape_letter),
      .advance       (advance),
      .empty         (empty),
      .pop           (pop),
      .result        (result)
   );

   assign rsp_word_text      = result.text;
   assign rsp_word_length    = result.length;
   assign rsp_entry_in_block = result.entry;
   assign rsp_too_long       = result.too_long;

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_word_length <= 4'(MAX_LETTERS))
      else $error("word length above letter capacity");

   a_too_long_saturates: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_too_long |-> rsp_word_length == 4'(MAX_LETTERS))
      else $error("too long word without saturated length");

   a_stall_holds_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.emit && !advance |=> cmd_valid && $stable(cmd))
      else $error("stalled word command changed");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop_head |-> head_valid)
      else $error("parser took an item from an empty front queue");

endmodule
